// File: design/ntaf_pkg.sv
// Package for the number-to-ASCII formatter: widths, format codes, ASCII
// constants, state types and the control structs passed between blocks.
// No dependencies.
`default_nettype none
package ntaf_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * 4;
    localparam int CNT_W   = $clog2(VALUE_W + 1);
    localparam int LEFT_W  = $clog2(DIGITS + 1);
    localparam int DEC4_W  = 16;

    localparam logic [LEFT_W-1:0] LEFT_SDEC = LEFT_W'(DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_DEC4 = LEFT_W'(4);
    localparam logic [LEFT_W-1:0] LEFT_HEX  = LEFT_W'(2);
    localparam logic [LEFT_W-1:0] LEFT_BIN  = LEFT_W'(8);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;

    typedef enum logic [MODE_W-1:0] {
        MODE_SDEC = 2'd0,
        MODE_DEC4 = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_BIN  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_CONV,
        TOP_LOAD,
        TOP_WAIT
    } t_top_state;

    typedef enum logic [1:0] {
        SER_IDLE,
        SER_SKIP,
        SER_SIGN,
        SER_EMIT
    } t_ser_state;

    typedef struct packed {
        logic  start;
        t_mode mode;
        logic  neg;
    } t_ser_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bcd_sts;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] w;
        w = {4'b0, nib};
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + w;
        end else begin
            hex_char = CH_A + w - 8'd10;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/ntaf_if.sv
// Valid/ready channel interfaces for the formatter: request side (mode, value)
// and character side (character, last). Depends on ntaf_pkg.
`default_nettype none
interface ntaf_in_if;
    import ntaf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [VALUE_W-1:0]  value;
    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ntaf_out_if;
    import ntaf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// File: design/ntaf_bcd.sv
// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
// Depends on ntaf_pkg.
`default_nettype none
module ntaf_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ntaf_pkg::VALUE_W-1:0]  i_bin,
    input  logic [ntaf_pkg::CNT_W-1:0]    i_nbits,
    output ntaf_pkg::t_bcd_sts            o_sts,
    output logic [ntaf_pkg::BCD_W-1:0]    o_bcd
);
    import ntaf_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   w_adj;
    logic [BCD_W-1:0]   n_bcd;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
        n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= i_nbits;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_cnt != '0) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_bcd      = r_bcd;

endmodule
`default_nettype wire

// File: design/ntaf_ser.sv
// Character serializer: skips leading zeros, inserts the sign, and shifts out
// one digit per character into a registered output. Depends on ntaf_pkg, ntaf_if.
`default_nettype none
module ntaf_ser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ntaf_pkg::t_ser_ctl          i_ctl,
    input  logic [ntaf_pkg::BCD_W-1:0]  i_bcd,
    input  logic [ntaf_pkg::CHAR_W-1:0] i_byte,
    ntaf_out_if.source                  o_chr,
    output logic                        o_busy
);
    import ntaf_pkg::*;

    t_ser_state         r_state, n_state;
    logic [BCD_W-1:0]   r_dig;
    logic [LEFT_W-1:0]  r_left;
    t_mode              r_mode;
    logic               r_neg;
    logic               r_ov;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [3:0]         w_top;
    logic [CHAR_W-1:0]  w_char;
    logic               w_room;
    logic               w_more;
    logic               w_skip;
    logic               w_load_sign;
    logic               w_load_dig;

    assign w_top  = r_dig[BCD_W-1 -: 4];
    assign w_room = !r_ov || o_chr.ready;
    assign w_more = (w_top == 4'd0) && (r_left > LEFT_W'(1));
    assign w_char = (r_mode == MODE_BIN) ? (CH_ZERO + {7'b0, r_dig[BCD_W-1]})
                                         : hex_char(w_top);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SER_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_ctl.mode == MODE_SDEC) ? SER_SKIP : SER_EMIT;
                end
            end
            SER_SKIP: begin
                if (!w_more) begin
                    n_state = r_neg ? SER_SIGN : SER_EMIT;
                end
            end
            SER_SIGN: begin
                if (w_room) begin
                    n_state = SER_EMIT;
                end
            end
            SER_EMIT: begin
                if (w_room && (r_left == LEFT_W'(1))) begin
                    n_state = SER_IDLE;
                end
            end
            default: n_state = SER_IDLE;
        endcase
    end

    always_comb begin
        w_skip      = (r_state == SER_SKIP) && w_more;
        w_load_sign = (r_state == SER_SIGN) && w_room;
        w_load_dig  = (r_state == SER_EMIT) && w_room;
        o_busy      = (r_state != SER_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SER_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_sign || w_load_dig) begin
                r_ov <= 1'b1;
            end else if (o_chr.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == SER_IDLE) && i_ctl.start) begin
            r_mode <= i_ctl.mode;
            r_neg  <= i_ctl.neg;
            unique case (i_ctl.mode)
                MODE_SDEC: begin
                    r_dig  <= i_bcd;
                    r_left <= LEFT_SDEC;
                end
                MODE_DEC4: begin
                    r_dig  <= {i_bcd[DEC4_W-1:0], (BCD_W-DEC4_W)'(0)};
                    r_left <= LEFT_DEC4;
                end
                MODE_HEX: begin
                    r_dig  <= {i_byte, (BCD_W-CHAR_W)'(0)};
                    r_left <= LEFT_HEX;
                end
                MODE_BIN: begin
                    r_dig  <= {i_byte, (BCD_W-CHAR_W)'(0)};
                    r_left <= LEFT_BIN;
                end
                default: begin
                    r_dig  <= i_bcd;
                    r_left <= LEFT_SDEC;
                end
            endcase
        end else if (w_skip) begin
            r_dig  <= {r_dig[BCD_W-5:0], 4'b0};
            r_left <= r_left - LEFT_W'(1);
        end else if (w_load_dig) begin
            r_char <= w_char;
            r_last <= (r_left == LEFT_W'(1));
            r_left <= r_left - LEFT_W'(1);
            if (r_mode == MODE_BIN) begin
                r_dig <= {r_dig[BCD_W-2:0], 1'b0};
            end else begin
                r_dig <= {r_dig[BCD_W-5:0], 4'b0};
            end
        end else if (w_load_sign) begin
            r_char <= CH_MINUS;
            r_last <= 1'b0;
        end
    end

    assign o_chr.valid     = r_ov;
    assign o_chr.character = r_char;
    assign o_chr.last      = r_last;

endmodule
`default_nettype wire

// File: design/number_to_ascii_formatter_top.sv
// Top level of the number-to-ASCII formatter: request intake and sequencing.
// Depends on ntaf_pkg, ntaf_if, ntaf_bcd, ntaf_ser.
//
// One request (mode, value) is taken at a time and turned into its ASCII
// characters, most significant first, with last set on the final one. Mode 0
// is signed decimal without leading zeros, mode 1 four digits of the low
// 16 bits modulo 10000, mode 2 two hex digits and mode 3 eight binary digits
// of the low byte. Decimal modes pass through a bit-serial shift-and-add-3
// converter that takes one bit per cycle. A request then passes through
// intake, the conversion and seeing it finish, a load into the serializer,
// in mode 0 the skipping of leading zeros out of ten digit places and a
// sign, the characters at one per cycle when the output does not stall, and
// the return to idle. The next request is taken once the final character
// sits in the output register, while it still waits to be taken.
`default_nettype none
module number_to_ascii_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntaf_in_if.sink     i_req,
    ntaf_out_if.source  o_chr
);
    import ntaf_pkg::*;

    t_top_state          r_state, n_state;
    t_mode               r_mode;
    logic                r_neg;
    logic [CHAR_W-1:0]   r_byte;

    t_mode               w_mode;
    logic                w_accept;
    logic                w_conv;
    logic [VALUE_W-1:0]  w_raw;
    logic [VALUE_W-1:0]  w_mag;
    logic [VALUE_W-1:0]  w_bin;
    logic [CNT_W-1:0]    w_nbits;
    t_bcd_sts            w_bcd_sts;
    logic [BCD_W-1:0]    w_bcd;
    t_ser_ctl            w_ser_ctl;
    logic                w_ser_busy;

    assign w_mode   = t_mode'(i_req.mode);
    assign w_raw    = i_req.value;
    assign i_req.ready = (r_state == TOP_IDLE) && !w_bcd_sts.busy;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_conv   = (w_mode == MODE_SDEC) || (w_mode == MODE_DEC4);
    assign w_mag    = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;

    always_comb begin
        if (w_mode == MODE_SDEC) begin
            w_bin   = w_mag;
            w_nbits = CNT_W'(VALUE_W);
        end else begin
            w_bin   = {w_raw[DEC4_W-1:0], (VALUE_W-DEC4_W)'(0)};
            w_nbits = CNT_W'(DEC4_W);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TOP_IDLE: begin
                if (w_accept) begin
                    n_state = w_conv ? TOP_CONV : TOP_LOAD;
                end
            end
            TOP_CONV: begin
                if (w_bcd_sts.done) begin
                    n_state = TOP_LOAD;
                end
            end
            TOP_LOAD: n_state = TOP_WAIT;
            TOP_WAIT: begin
                if (!w_ser_busy) begin
                    n_state = TOP_IDLE;
                end
            end
            default: n_state = TOP_IDLE;
        endcase
    end

    always_comb begin
        w_ser_ctl.start = (r_state == TOP_LOAD);
        w_ser_ctl.mode  = r_mode;
        w_ser_ctl.neg   = r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TOP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= w_mode;
            r_neg  <= (w_mode == MODE_SDEC) && w_raw[VALUE_W-1];
            r_byte <= w_raw[CHAR_W-1:0];
        end
    end

    ntaf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_conv),
        .i_bin   (w_bin),
        .i_nbits (w_nbits),
        .o_sts   (w_bcd_sts),
        .o_bcd   (w_bcd)
    );

    ntaf_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ser_ctl),
        .i_bcd   (w_bcd),
        .i_byte  (r_byte),
        .o_chr   (o_chr),
        .o_busy  (w_ser_busy)
    );

endmodule
`default_nettype wire

// File: design/ntaf_chk.sv
// Port-level checker for the formatter, bound to the top level.
// Depends on ntaf_pkg and number_to_ascii_formatter_top.
`default_nettype none
module ntaf_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ntaf_pkg::CHAR_W-1:0] i_out_char,
    input logic                        i_out_last
);
    import ntaf_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one still in work");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_char >= CH_ZERO) && (i_out_char <= CH_NINE))
                     || (i_out_char == CH_MINUS)
                     || ((i_out_char >= CH_A) && (i_out_char <= CH_F)))
        else $error("illegal character");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char == CH_MINUS) |-> !i_out_last)
        else $error("sign marked as last character");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
                                        && $stable(i_out_last))
        else $error("stalled character changed");

endmodule

bind number_to_ascii_formatter_top ntaf_chk u_ntaf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_chr.valid),
    .i_out_ready (o_chr.ready),
    .i_out_char  (o_chr.character),
    .i_out_last  (o_chr.last)
);
`default_nettype wire

// File: test/ntaf_format_checker.sv
// Checker for the number-to-ASCII formatter: watches the request and character
// channels, predicts the characters of every accepted request and compares.
// Depends on ntaf_pkg.
`default_nettype none
module ntaf_format_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic [ntaf_pkg::MODE_W-1:0]  i_req_mode,
    input  logic [ntaf_pkg::VALUE_W-1:0] i_req_value,
    input  logic                         i_chr_valid,
    input  logic                         i_chr_ready,
    input  logic [ntaf_pkg::CHAR_W-1:0]  i_chr_character,
    input  logic                         i_chr_last,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_req_count,
    output int                           o_char_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ntaf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_ascii_char;

    t_ascii_char pending_chars[$];

    function automatic void add_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        t_ascii_char c;
        c.character = ch;
        c.last      = is_last;
        pending_chars.push_back(c);
    endfunction

    // Characters of one request, most significant first.
    function automatic void format_chars(input t_mode fmt, input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digs [0:DIGITS-1];
        logic [3:0]         nib;
        int                 nd;
        int                 v4;
        case (fmt)
            MODE_SDEC: begin
                if (raw == '0) begin
                    add_char(CH_ZERO, 1'b1);
                end else begin
                    if (raw[VALUE_W-1]) begin
                        add_char(CH_MINUS, 1'b0);
                        mag = -raw;
                    end else begin
                        mag = raw;
                    end
                    nd = 0;
                    while (mag != '0) begin
                        digs[nd] = 4'(mag % 32'd10);
                        mag      = mag / 32'd10;
                        nd++;
                    end
                    for (int i = nd - 1; i >= 0; i--) begin
                        add_char(CH_ZERO + {4'b0, digs[i]}, i == 0);
                    end
                end
            end
            MODE_DEC4: begin
                v4 = int'(raw[DEC4_W-1:0]) % 10000;
                add_char(CH_ZERO + 8'(v4 / 1000), 1'b0);
                add_char(CH_ZERO + 8'((v4 % 1000) / 100), 1'b0);
                add_char(CH_ZERO + 8'((v4 % 100) / 10), 1'b0);
                add_char(CH_ZERO + 8'(v4 % 10), 1'b1);
            end
            MODE_HEX: begin
                for (int k = 1; k >= 0; k--) begin
                    nib = raw[4*k +: 4];
                    if (nib < 4'd10) begin
                        add_char(CH_ZERO + {4'b0, nib}, k == 0);
                    end else begin
                        add_char(CH_A + {4'b0, nib} - 8'd10, k == 0);
                    end
                end
            end
            default: begin
                for (int b = 7; b >= 0; b--) begin
                    add_char(CH_ZERO + {7'b0, raw[b]}, b == 0);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_ascii_char want;
        if (!i_rst_n) begin
            pending_chars.delete();
            o_fail_count = 0;
            o_req_count  = 0;
            o_char_count = 0;
        end else begin
            if (i_chr_valid && i_chr_ready) begin
                o_char_count++;
                if (pending_chars.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected character 0x%02h last %0b, none pending",
                                 $realtime, i_chr_character, i_chr_last);
                    end
                    o_fail_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (want.character !== i_chr_character || want.last !== i_chr_last) begin
                        if (o_fail_count < 10) begin
                            $display({"%0t: character %0d: expected 0x%02h last %0b,",
                                      " got 0x%02h last %0b"},
                                     $realtime, o_char_count, want.character, want.last,
                                     i_chr_character, i_chr_last);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                o_req_count++;
                format_chars(t_mode'(i_req_mode), i_req_value);
            end
        end
        o_pending = pending_chars.size();
    end

endmodule
`default_nettype wire

// File: test/tb_number_to_ascii_formatter_top.sv
// Testbench top for the number-to-ASCII formatter: clock, reset, request
// stimulus with bursts and gaps, character-side stalls and the verdict.
// Depends on ntaf_pkg, ntaf_if, number_to_ascii_formatter_top, ntaf_format_checker.
`default_nettype none
module tb_number_to_ascii_formatter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ntaf_pkg::*;

    localparam int RANDOM_REQUESTS = 255;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   req_count;
    int   char_count;
    int   burst_left;
    int   directed_count;

    ntaf_in_if  req_if ();
    ntaf_out_if chr_if ();

    number_to_ascii_formatter_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_chr   (chr_if)
    );

    ntaf_format_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_mode      (req_if.mode),
        .i_req_value     (req_if.value),
        .i_chr_valid     (chr_if.valid),
        .i_chr_ready     (chr_if.ready),
        .i_chr_character (chr_if.character),
        .i_chr_last      (chr_if.last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_req_count     (req_count),
        .o_char_count    (char_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d characters still pending", CYCLE_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Character side: picks a new random stall style after each span of random length.
    initial begin
        int style;
        int span;
        chr_if.ready = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 80);
            for (int phase = 0; phase < span; phase++) begin
                @(negedge clk);
                case (style)
                    0:       chr_if.ready = 1'b1;
                    1:       chr_if.ready = ($urandom_range(0, 3) != 0);
                    2:       chr_if.ready = (phase % 4 == 3);
                    default: chr_if.ready = ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    task automatic send_request(input t_mode m, input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            req_if.valid = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        req_if.valid = 1'b1;
        req_if.mode  = m;
        req_if.value = v;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    initial begin
        logic [VALUE_W-1:0] v;
        t_mode              m;
        int                 sel;
        int                 k;
        longint             p;
        req_if.valid = 1'b0;
        req_if.mode  = MODE_SDEC;
        req_if.value = '0;
        burst_left   = 0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(MODE_SDEC, 32'd0);
        send_request(MODE_SDEC, 32'd7);
        send_request(MODE_SDEC, 32'hFFFF_FFFF);
        send_request(MODE_SDEC, 32'd10);
        send_request(MODE_SDEC, -32'd10);
        send_request(MODE_SDEC, 32'h7FFF_FFFF);
        send_request(MODE_SDEC, 32'h8000_0000);
        send_request(MODE_SDEC, 32'd1000000000);
        send_request(MODE_SDEC, -32'd999999999);
        send_request(MODE_SDEC, 32'd4);
        send_request(MODE_DEC4, 32'd0);
        send_request(MODE_DEC4, 32'd9999);
        send_request(MODE_DEC4, 32'd10000);
        send_request(MODE_DEC4, 32'h0000_FFFF);
        send_request(MODE_DEC4, 32'hFFFF_0000);
        send_request(MODE_DEC4, 32'h0001_270F);
        send_request(MODE_HEX, 32'h0000_0000);
        send_request(MODE_HEX, 32'h0000_00FF);
        send_request(MODE_HEX, 32'hFFFF_FF9A);
        send_request(MODE_HEX, 32'h1234_56A5);
        send_request(MODE_HEX, 32'h0000_003C);
        send_request(MODE_BIN, 32'h0000_0000);
        send_request(MODE_BIN, 32'h0000_00FF);
        send_request(MODE_BIN, 32'h1234_56A5);
        send_request(MODE_BIN, 32'hFFFF_FF5A);
        directed_count = req_count;

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) begin
                // let the block drain completely before carrying on
                req_if.valid = 1'b0;
                while (pending != 0) @(negedge clk);
                burst_left = 0;
            end
            sel = $urandom_range(0, 9);
            m   = (sel < 4) ? MODE_SDEC : t_mode'($urandom_range(1, 3));
            k   = $urandom_range(1, 9);
            p   = 1;
            repeat (k) p = p * 10;
            case ($urandom_range(0, 4))
                0:       v = $urandom;
                1:       v = $urandom_range(0, 20);
                4:       v = 32'(p) + $urandom_range(0, 2) - 1;
                default: v = 32'($urandom % p);
            endcase
            if ($urandom_range(0, 1)) begin
                v = -v;
            end
            send_request(m, v);
        end

        req_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Formatted %0d numbers (%0d directed edge values) into %0d characters",
                 req_count, directed_count, char_count);
        $display("Mismatches: %0d, characters still pending: %0d", fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
